[rtl/sjfrl_pkg.sv]
// ----------------------------------------------------------------------------
// sjfrl_pkg
// Shared types, codes and defaults for the shortest-job-first resource lock.
// ----------------------------------------------------------------------------
package sjfrl_pkg;

  // default sizes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 15;
  localparam int DEF_TIME_BITS   = 16;

  // response status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_GRANT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_POLICY_MODE = 1'b0;

  // policy values
  localparam logic POLICY_SJF  = 1'b0;
  localparam logic POLICY_FCFS = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  // per-cycle operation broadcast to every queue cell
  typedef struct packed {
    logic match;   // compare stored id with request id
    logic insert;  // first free cell takes the request
    logic scan;    // advance the running-minimum chain
    logic shift;   // cells at or above the taken slot pull from their neighbor
  } cell_op_t;

endpackage

[rtl/sjfrl_if.sv]
// ----------------------------------------------------------------------------
// sjfrl_req_if / sjfrl_rsp_if
// Valid/ready channels for lock requests and lock responses.
// ----------------------------------------------------------------------------
interface sjfrl_req_if #(
  parameter int ID_BITS   = 15,
  parameter int TIME_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [ID_BITS-1:0]   requester_id;
  logic [TIME_BITS-1:0] job_time;

  modport source (output valid, output requester_id, output job_time, input ready);
  modport sink   (input valid, input requester_id, input job_time, output ready);
endinterface

interface sjfrl_rsp_if #(
  parameter int ID_BITS = 15
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ID_BITS-1:0] owner_id;
  logic               owner_valid;

  modport source (output valid, output status, output owner_id, output owner_valid,
                  input ready);
  modport sink   (input valid, input status, input owner_id, input owner_valid,
                  output ready);
endinterface

[rtl/sjfrl_regs.sv]
// ----------------------------------------------------------------------------
// sjfrl_regs
// APB register block holding the release policy.
// ----------------------------------------------------------------------------
module sjfrl_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sjfrl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sjfrl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sjfrl_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output logic                             policy_mode
);
  import sjfrl_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 hit_policy;

  assign reg_idx    = paddr[APB_ADDR_W-1:2];
  assign hit_policy = (reg_idx == REG_POLICY_MODE);
  assign pready     = 1'b1;

  // write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= POLICY_SJF;
    end else if (psel && penable && pwrite && hit_policy) begin
      policy_mode <= pwdata[0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (hit_policy) begin
      prdata[0] = policy_mode;
    end
  end

endmodule

[rtl/sjfrl_cell.sv]
// ----------------------------------------------------------------------------
// sjfrl_cell
// One waiting-list slot: stores an id and job time, flags an id match, and
// passes the running minimum and the shift data along the chain.
// ----------------------------------------------------------------------------
module sjfrl_cell #(
  parameter int CELL_IDX  = 0,
  parameter int CNT_W     = 5,
  parameter int SLOT_W    = 4,
  parameter int ID_BITS   = 15,
  parameter int TIME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sjfrl_pkg::cell_op_t   op,
  input  logic [CNT_W-1:0]      count,
  input  logic [SLOT_W-1:0]     sel_slot,
  input  logic [ID_BITS-1:0]    req_id,
  input  logic [TIME_BITS-1:0]  req_time,
  // data from the next cell up (for compaction)
  input  logic [ID_BITS-1:0]    up_id,
  input  logic [TIME_BITS-1:0]  up_time,
  output logic [ID_BITS-1:0]    id,
  output logic [TIME_BITS-1:0]  tm,
  output logic                  hit,
  // running minimum from the cell below, and onward
  input  logic                  best_in_found,
  input  logic [TIME_BITS-1:0]  best_in_time,
  input  logic [SLOT_W-1:0]     best_in_slot,
  input  logic [ID_BITS-1:0]    best_in_id,
  output logic                  best_found,
  output logic [TIME_BITS-1:0]  best_time,
  output logic [SLOT_W-1:0]     best_slot,
  output logic [ID_BITS-1:0]    best_id
);
  import sjfrl_pkg::*;

  localparam logic [CNT_W-1:0]  IDX_C = CNT_W'(CELL_IDX);
  localparam logic [SLOT_W-1:0] IDX_S = SLOT_W'(CELL_IDX);

  logic occ;
  logic take;

  assign occ  = (IDX_C < count);
  // strictly smaller replaces, so the earliest entry wins a tie
  assign take = occ && (!best_in_found || (tm < best_in_time));

  // slot contents
  always_ff @(posedge clk) begin
    if (op.insert && (IDX_C == count)) begin
      id <= req_id;
      tm <= req_time;
    end else if (op.shift && (IDX_S >= sel_slot)) begin
      id <= up_id;
      tm <= up_time;
    end
  end

  // id match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (op.match) begin
      hit <= occ && (id == req_id);
    end
  end

  // running minimum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (op.scan) begin
      best_found <= best_in_found || occ;
    end
  end

  always_ff @(posedge clk) begin
    if (op.scan) begin
      if (take) begin
        best_time <= tm;
        best_slot <= IDX_S;
        best_id   <= id;
      end else begin
        best_time <= best_in_time;
        best_slot <= best_in_slot;
        best_id   <= best_in_id;
      end
    end
  end

endmodule

[rtl/sjf_resource_lock_scheduler.sv]
// ----------------------------------------------------------------------------
// sjf_resource_lock_scheduler
// Lock for one shared resource with a shortest-job-first waiting list.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request that grants, waits, is refused
// or is a repeat from the owner goes from accept through an id match across
// all slots and a decision to the response word. A release by the owner in
// first-come mode adds a list compaction step; in shortest-job mode the
// running minimum is first carried from slot to slot through the chain of
// queue cells, one slot per cycle, and then the list closes the gap. A new
// request is taken as soon as the response word is registered, even while
// that word still waits to be taken.
// ----------------------------------------------------------------------------
module sjf_resource_lock_scheduler #(
  parameter int QUEUE_DEPTH = sjfrl_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = sjfrl_pkg::DEF_ID_BITS,
  parameter int TIME_BITS   = sjfrl_pkg::DEF_TIME_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  sjfrl_req_if.sink                        req,
  sjfrl_rsp_if.source                      rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sjfrl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sjfrl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sjfrl_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import sjfrl_pkg::*;

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

  // configuration
  logic policy_mode;

  sjfrl_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .policy_mode (policy_mode)
  );

  // control registers
  state_t                state, state_next;
  logic                  busy, busy_next;
  logic [ID_BITS-1:0]    owner, owner_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [SLOT_W-1:0]     scan_cnt, scan_cnt_next;
  logic [STATUS_W-1:0]   status, status_next;
  logic                  out_vld;
  logic                  out_load;
  cell_op_t              op;

  // latched request
  logic [ID_BITS-1:0]    rid;
  logic [TIME_BITS-1:0]  rtm;
  logic                  req_acc;

  // cell chain wiring
  logic [ID_BITS-1:0]    c_id        [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  c_tm        [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_hit;
  logic                  b_found     [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  b_time      [QUEUE_DEPTH];
  logic [SLOT_W-1:0]     b_slot      [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    b_id        [QUEUE_DEPTH];

  // slot taken by a release: scan result in shortest-job mode, else the head
  logic [SLOT_W-1:0]     shift_slot;

  logic any_hit;
  assign any_hit = |c_hit;

  assign shift_slot = (policy_mode == POLICY_SJF) ? b_slot[QUEUE_DEPTH-1] : '0;

  // queue cells
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [ID_BITS-1:0]   up_id;
    logic [TIME_BITS-1:0] up_tm;
    logic                 in_found;
    logic [TIME_BITS-1:0] in_time;
    logic [SLOT_W-1:0]    in_slot;
    logic [ID_BITS-1:0]   in_id;

    if (k == QUEUE_DEPTH - 1) begin : g_top
      assign up_id = c_id[k];
      assign up_tm = c_tm[k];
    end else begin : g_mid
      assign up_id = c_id[k+1];
      assign up_tm = c_tm[k+1];
    end

    if (k == 0) begin : g_first
      assign in_found = 1'b0;
      assign in_time  = '0;
      assign in_slot  = '0;
      assign in_id    = '0;
    end else begin : g_next
      assign in_found = b_found[k-1];
      assign in_time  = b_time[k-1];
      assign in_slot  = b_slot[k-1];
      assign in_id    = b_id[k-1];
    end

    sjfrl_cell #(
      .CELL_IDX  (k),
      .CNT_W     (CNT_W),
      .SLOT_W    (SLOT_W),
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .op            (op),
      .count         (count),
      .sel_slot      (shift_slot),
      .req_id        (rid),
      .req_time      (rtm),
      .up_id         (up_id),
      .up_time       (up_tm),
      .id            (c_id[k]),
      .tm            (c_tm[k]),
      .hit           (c_hit[k]),
      .best_in_found (in_found),
      .best_in_time  (in_time),
      .best_in_slot  (in_slot),
      .best_in_id    (in_id),
      .best_found    (b_found[k]),
      .best_time     (b_time[k]),
      .best_slot     (b_slot[k]),
      .best_id       (b_id[k])
    );
  end

  // request channel
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (req_acc) begin
      rid <= req.requester_id;
      rtm <= req.job_time;
    end
  end

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      busy     <= 1'b0;
      owner    <= '0;
      count    <= '0;
      scan_cnt <= '0;
      status   <= ST_GRANT;
    end else begin
      state    <= state_next;
      busy     <= busy_next;
      owner    <= owner_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
      status   <= status_next;
    end
  end

  // next state and cell operations
  always_comb begin
    state_next    = state;
    busy_next     = busy;
    owner_next    = owner;
    count_next    = count;
    scan_cnt_next = scan_cnt;
    status_next   = status;
    op            = '0;
    out_load      = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_acc) begin
          state_next = S_MATCH;
        end
      end

      S_MATCH: begin
        op.match   = 1'b1;
        state_next = S_DECIDE;
      end

      S_DECIDE: begin
        state_next = S_RESULT;
        if (busy && (owner == rid)) begin
          status_next = ST_GRANT;
          if (rtm == '0) begin
            if (count != '0) begin
              if (policy_mode == POLICY_FCFS) begin
                owner_next    = c_id[0];
                state_next    = S_SHIFT;
              end else begin
                scan_cnt_next = '0;
                state_next    = S_SCAN;
              end
            end else begin
              busy_next  = 1'b0;
              owner_next = '0;
            end
          end
        end else if (busy) begin
          if (any_hit) begin
            status_next = ST_WAIT;
          end else if (count == FULL_CNT) begin
            status_next = ST_FULL;
          end else begin
            op.insert   = 1'b1;
            count_next  = count + 1'b1;
            status_next = ST_WAIT;
          end
        end else begin
          busy_next   = 1'b1;
          owner_next  = rid;
          status_next = ST_GRANT;
        end
      end

      // carry the minimum through every cell
      S_SCAN: begin
        op.scan       = 1'b1;
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == LAST_SLOT) begin
          state_next = S_SHIFT;
        end
      end

      // scan result is ready in the last cell on entry here after a scan
      S_SHIFT: begin
        op.shift   = 1'b1;
        count_next = count - 1'b1;
        if (policy_mode == POLICY_SJF) begin
          owner_next = b_id[QUEUE_DEPTH-1];
        end
        state_next = S_RESULT;
      end

      S_RESULT: begin
        if (!out_vld || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status      <= status;
      rsp.owner_id    <= owner;
      rsp.owner_valid <= busy;
    end
  end

  assign rsp.valid = out_vld;

endmodule

[tb/sjf_resource_lock_scheduler_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sjf_resource_lock_scheduler_test
// Drives lock requests and register writes into the scheduler and checks
// every response word against a behavioral copy of the lock and its list,
// or against the word that a typed row of the directed table gives.
// A short table of directed requests walks the idle, owner, waiter, full and
// release paths; then six random phases run with both policies, changing
// release pressure, random idling on both channels and one quiet stretch.
// ----------------------------------------------------------------------------
module sjf_resource_lock_scheduler_test;
  import sjfrl_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int ID_W  = DEF_ID_BITS;
  localparam int TM_W  = DEF_TIME_BITS;
  localparam int POOL  = 24;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 300;

  // register addresses: policy and one slot past the register list
  localparam logic [APB_ADDR_W-1:0] ADDR_POLICY = {REG_POLICY_MODE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE  = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     owner_id;
    logic                owner_valid;
  } lock_word_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic [TM_W-1:0] jt;
    bit              typed;
    lock_word_t      want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sjfrl_req_if #(.ID_BITS(ID_W), .TIME_BITS(TM_W)) req_if ();
  sjfrl_rsp_if #(.ID_BITS(ID_W)) rsp_if ();

  sjf_resource_lock_scheduler #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS    (ID_W),
    .TIME_BITS  (TM_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_if.sink),
    .rsp    (rsp_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // lock state as the scheduler should hold it
  logic            policy;
  logic [ID_W-1:0] own_id;
  logic            own_busy;
  logic [ID_W-1:0] wl_id   [DEPTH];
  logic [TM_W-1:0] wl_time [DEPTH];
  int              wl_cnt;

  lock_word_t lock_q[$];     // response words still owed by the scheduler
  dir_row_t   dir_rows[$];
  int         fails = 0;
  bit         quiet;         // no idling on either side

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one request to the lock state, return the response word it earns
  function automatic lock_word_t lock_next(input logic [ID_W-1:0] id,
                                           input logic [TM_W-1:0] jt);
    lock_word_t w;
    int         pick;
    bit         found;
    w.status = ST_GRANT;
    if (own_busy && own_id == id) begin
      // owner: zero time hands over or goes idle, anything else is a no-op
      if (jt == '0) begin
        if (wl_cnt > 0) begin
          pick = 0;
          if (policy == POLICY_SJF) begin
            for (int i = 1; i < wl_cnt; i++)
              if (wl_time[i] < wl_time[pick]) pick = i;
          end
          own_id = wl_id[pick];
          for (int i = pick; i < wl_cnt - 1; i++) begin
            wl_id[i]   = wl_id[i+1];
            wl_time[i] = wl_time[i+1];
          end
          wl_cnt--;
        end else begin
          own_busy = 1'b0;
          own_id   = '0;
        end
      end
    end else if (own_busy) begin
      found = 1'b0;
      for (int i = 0; i < wl_cnt; i++)
        if (wl_id[i] == id) found = 1'b1;
      if (found) begin
        w.status = ST_WAIT;
      end else if (wl_cnt >= DEPTH) begin
        w.status = ST_FULL;
      end else begin
        wl_id[wl_cnt]   = id;
        wl_time[wl_cnt] = jt;
        wl_cnt++;
        w.status = ST_WAIT;
      end
    end else begin
      own_id   = id;
      own_busy = 1'b1;
    end
    w.owner_id    = own_busy ? own_id : '0;
    w.owner_valid = own_busy;
    return w;
  endfunction

  // send one request word; typed rows carry their own expected response
  task automatic send_word(input logic [ID_W-1:0] id, input logic [TM_W-1:0] jt,
                           input bit typed, input lock_word_t want);
    lock_word_t pred;
    if (!quiet && $urandom_range(99) < 22) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.requester_id <= id;
    req_if.job_time     <= jt;
    do @(posedge clk); while (!req_if.ready);
    pred = lock_next(id, jt);
    lock_q.push_back(typed ? want : pred);
  endtask

  // register write, only while the scheduler is idle
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((addr >> 2) == REG_POLICY_MODE) policy = data[0];
  endtask

  // wait until every owed response word has arrived
  task automatic drain_words();
    req_if.valid <= 1'b0;
    while (lock_q.size() != 0) @(posedge clk);
  endtask

  // response side: random back-pressure
  always @(posedge clk) begin
    rsp_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // compare each accepted response word with the oldest expectation
  always @(posedge clk) begin
    lock_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (lock_q.size() == 0) begin
        $error("unexpected response word: status %0d owner_id %0h owner_valid %0b",
               rsp_if.status, rsp_if.owner_id, rsp_if.owner_valid);
        fails++;
      end else begin
        want = lock_q.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          fails++;
        end
        if (rsp_if.owner_id !== want.owner_id) begin
          $error("owner_id: expected %0h, actual %0h", want.owner_id, rsp_if.owner_id);
          fails++;
        end
        if (rsp_if.owner_valid !== want.owner_valid) begin
          $error("owner_valid: expected %0b, actual %0b",
                 want.owner_valid, rsp_if.owner_valid);
          fails++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("sjf_resource_lock_scheduler_test failed");
    $finish;
  end

  // main sequence
  initial begin
    logic [ID_W-1:0]       pool[POOL];
    logic [ID_W-1:0]       id;
    logic [TM_W-1:0]       jt;
    logic [APB_ADDR_W-1:0] ph_addr[PHASES];
    logic [APB_DATA_W-1:0] ph_data[PHASES];
    int                    ph_rel[PHASES];
    ph_addr = '{ADDR_POLICY, ADDR_POLICY, ADDR_SPARE, ADDR_POLICY, ADDR_POLICY,
                ADDR_POLICY};
    ph_data = '{32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0000_0000, 32'h0000_0001};
    ph_rel  = '{15, 35, 10, 40, 25, 20};

    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_if.valid        = 1'b0;
    req_if.requester_id = '0;
    req_if.job_time     = '0;
    quiet               = 1'b0;
    policy              = POLICY_SJF;
    own_id              = '0;
    own_busy            = 1'b0;
    wl_cnt              = 0;

    // directed table: idle take, release with empty list, zero time while
    // idle, owner repeat, list filled, duplicate on a full list, full list,
    // then releases in shortest-job order with a tie
    dir_rows.push_back('{15'h0000, 16'h0000, 1'b1, '{ST_GRANT, 15'h0000, 1'b1}});
    dir_rows.push_back('{15'h0000, 16'h0000, 1'b1, '{ST_GRANT, 15'h0000, 1'b0}});
    dir_rows.push_back('{15'h7FFF, 16'h0000, 1'b1, '{ST_GRANT, 15'h7FFF, 1'b1}});
    dir_rows.push_back('{15'h7FFF, 16'hFFFF, 1'b1, '{ST_GRANT, 15'h7FFF, 1'b1}});
    for (int i = 0; i < DEPTH; i++) begin
      jt = (i == 0) ? 16'hFFFF : (i == 2 || i == 3) ? 16'h0000 : TM_W'(i * 100);
      dir_rows.push_back('{ID_W'(i), jt, 1'b1, '{ST_WAIT, 15'h7FFF, 1'b1}});
    end
    dir_rows.push_back('{15'h0001, 16'h0007, 1'b1, '{ST_WAIT, 15'h7FFF, 1'b1}});
    dir_rows.push_back('{15'h4000, 16'h0005, 1'b1, '{ST_FULL, 15'h7FFF, 1'b1}});
    dir_rows.push_back('{15'h7FFF, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{15'h0002, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{15'h0003, 16'h0000, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r])
      send_word(dir_rows[r].id, dir_rows[r].jt, dir_rows[r].typed, dir_rows[r].want);

    // random phases, each behind a register write on an idle scheduler
    for (int p = 0; p < PHASES; p++) begin
      drain_words();
      reg_write(ph_addr[p], ph_data[p]);
      foreach (pool[k]) pool[k] = ID_W'($urandom_range(0, 32767));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        quiet = (p == 1 && n < 150);
        // one pause mid-phase until every owed word is back
        if (p == 2 && n == 150) drain_words();
        if (own_busy && $urandom_range(99) < ph_rel[p]) begin
          id = own_id;
          jt = '0;
        end else begin
          id = ($urandom_range(99) < 12) ? ID_W'($urandom) : pool[$urandom_range(0, POOL-1)];
          case ($urandom_range(3))
            0:       jt = TM_W'($urandom_range(0, 7));
            1:       jt = TM_W'($urandom);
            2:       jt = TM_W'($urandom_range(0, 255));
            default: jt = $urandom_range(1) ? '1 : '0;
          endcase
        end
        send_word(id, jt, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    drain_words();
    repeat (DEPTH + 8) @(posedge clk);
    if (fails == 0) begin
      $display("sjf_resource_lock_scheduler_test passed");
    end else begin
      $display("sjf_resource_lock_scheduler_test failed");
    end
    $finish;
  end

endmodule
